@@ rtl/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

@@ rtl/arpc_pkg.sv @@
package arpc_pkg;
  localparam int CacheDepthDef = 32;
  localparam int RequestDepthDef = 16;
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_APPEND = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;
  localparam logic [2:0] K_LOOKUP  = 3'd0;
  localparam logic [2:0] K_INSERT  = 3'd1;
  localparam logic [2:0] K_RELEASE = 3'd2;
  localparam logic [2:0] K_SEND    = 3'd3;
  localparam logic [2:0] K_QUEUED  = 3'd4;
  localparam logic [2:0] K_UNREACH = 3'd5;
  localparam logic [2:0] K_TICK    = 3'd6;
  localparam logic [2:0] K_FULL    = 3'd7;
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_TRIES   = 1'b1;
  localparam logic [7:0] TimeoutRst = 8'd15;
  localparam logic [3:0] TriesRst = 4'd5;
  localparam logic [15:0] LfsrRst = 16'hACE1;
  typedef enum logic [2:0] {
    ST_IDLE, ST_CSCAN, ST_CWRITE, ST_RSCAN, ST_DONE
  } state_t;
  typedef struct packed {
    logic       ip_eq;
    logic       port_eq;
  } cmp_t;
endpackage

@@ rtl/arpc_ram.sv @@
module arpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/arpc_cmp.sv @@
// Shared compare unit: stored IP/port against the command
module arpc_cmp (
  input  logic [31:0]        a_ip,
  input  logic [31:0]        b_ip,
  input  logic [3:0]         a_port,
  input  logic [3:0]         b_port,
  output arpc_pkg::cmp_t     res
);
  assign res.ip_eq = (a_ip == b_ip);
  assign res.port_eq = (a_port == b_port);
endmodule

@@ rtl/arp_cache_with_pending_requests.sv @@
// ARP cache with pending requests. A command (start while !busy) is executed
// by a sequencer stepping one entry per cycle through a single IP/port
// compare unit over a cache RAM and a request RAM (registered read). Lookup
// scans all CACHE_DEPTH entries; append scans the requests only. Insert scans
// the cache, writes the new entry (ST_CWRITE), then scans the requests; tick
// scans the cache, the requests, then gives its closing result (ST_DONE). At
// most one result leaves per cycle. The insert-done result is held one step
// so that it can carry out_last when no request gets released. Results appear
// on out_* for one cycle with out_valid high; the receiver cannot stall them,
// so the block never waits on it. out_last marks the final result of each
// item. Valid bits live in flip-flops; the RAM contents need no clearing
// after reset.
`include "assert_macros.svh"
module arp_cache_with_pending_requests #(
  parameter int CACHE_DEPTH = arpc_pkg::CacheDepthDef,
  parameter int REQUEST_DEPTH = arpc_pkg::RequestDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_ip_addr,
  input  logic [47:0] in_mac_in,
  input  logic [3:0]  in_port,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic        out_hit,
  output logic [31:0] out_ip_out,
  output logic [3:0]  out_port_out,
  output logic [47:0] out_mac_out,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int RW = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
  localparam int RD = (REQUEST_DEPTH > 1) ? REQUEST_DEPTH : 2;
  localparam int CCW = $clog2(CACHE_DEPTH + 1);
  localparam int RCW = $clog2(REQUEST_DEPTH + 1);
  // entry word: ip, mac, age ; request word: ip, port, tries
  localparam int EW = 88;
  localparam int QW = 40;
  // victim slot = lfsr mod CACHE_DEPTH by reciprocal multiply, exact for 16 bits
  localparam int VK = 16 + CW;
  localparam logic [16:0] VMUL =
    17'(((64'd1 << VK) + 64'(CACHE_DEPTH) - 64'd1) / 64'(CACHE_DEPTH));

  arpc_pkg::state_t st_r, st_nxt;
  logic [7:0] tmo_r;
  logic [3:0] tries_max_r;
  logic [15:0] lfsr_r, lfsr_nxt;
  logic [CACHE_DEPTH-1:0] ev_r, ev_nxt;
  logic [REQUEST_DEPTH-1:0] rv_r, rv_nxt;
  logic [1:0] act_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic [3:0] port_r;
  // scan counter: issued address; pipe valid for read data of previous address
  logic [CCW-1:0] ccnt_r, ccnt_nxt;
  logic [RCW-1:0] rcnt_r, rcnt_nxt;
  logic pv_r, pv_nxt;
  logic [CW-1:0] paddr_c_r, paddr_c_nxt;
  logic [RW-1:0] paddr_r_r, paddr_r_nxt;
  logic found_r, found_nxt;
  logic [CW-1:0] fidx_r, fidx_nxt;
  logic [47:0] fmac_r, fmac_nxt;
  logic freef_r, freef_nxt;
  logic [RW-1:0] ridx_r, ridx_nxt;
  // insert result held back one step (insert done, then each release)
  logic [2:0] hkind_r, hkind_nxt;
  logic [3:0] hport_r, hport_nxt;
  // lfsr quotient; lfsr only moves on a write cycle, long after the last one
  logic [15:0] vq_r;
  logic [15:0] vrem;

  logic c_we, r_we;
  logic [CW-1:0] c_waddr, c_raddr;
  logic [EW-1:0] c_wdata, c_rdata;
  logic [RW-1:0] r_waddr, r_raddr;
  logic [QW-1:0] r_wdata, r_rdata;

  logic        ov_nxt, hit_nxt, last_nxt;
  logic [2:0]  kind_nxt;
  logic [31:0] oip_nxt;
  logic [3:0]  oport_nxt;
  logic [47:0] omac_nxt;

  logic [31:0] cmp_a;
  logic [3:0]  cmp_pa;
  arpc_pkg::cmp_t cmp;

  arpc_ram #(.Width(EW), .Depth(CACHE_DEPTH)) u_cram (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata));
  arpc_ram #(.Width(QW), .Depth(RD)) u_rram (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));

  // one compare path, fed by cache or request read data
  assign cmp_a  = (st_r == arpc_pkg::ST_CSCAN) ? c_rdata[87:56] : r_rdata[39:8];
  assign cmp_pa = r_rdata[7:4];
  arpc_cmp u_cmp (.a_ip(cmp_a), .b_ip(ip_r), .a_port(cmp_pa), .b_port(port_r), .res(cmp));

  assign busy = (st_r != arpc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign vrem = lfsr_r - 16'(vq_r * 16'(CACHE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= arpc_pkg::ST_IDLE;
      tmo_r <= arpc_pkg::TimeoutRst;
      tries_max_r <= arpc_pkg::TriesRst;
      lfsr_r <= arpc_pkg::LfsrRst;
      ev_r <= '0;
      rv_r <= '0;
      out_valid <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      lfsr_r <= lfsr_nxt;
      ev_r <= ev_nxt;
      rv_r <= rv_nxt;
      out_valid <= ov_nxt;
      pv_r <= pv_nxt;
      if (cfg_valid) begin
        if (cfg_index == arpc_pkg::CFG_TIMEOUT) tmo_r <= cfg_data;
        else tries_max_r <= cfg_data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r <= in_action;
      ip_r <= in_ip_addr;
      mac_r <= in_mac_in;
      port_r <= in_port;
    end
    ccnt_r <= ccnt_nxt;
    rcnt_r <= rcnt_nxt;
    paddr_c_r <= paddr_c_nxt;
    paddr_r_r <= paddr_r_nxt;
    found_r <= found_nxt;
    fidx_r <= fidx_nxt;
    fmac_r <= fmac_nxt;
    freef_r <= freef_nxt;
    ridx_r <= ridx_nxt;
    hkind_r <= hkind_nxt;
    hport_r <= hport_nxt;
    vq_r <= 16'((33'(lfsr_r) * 33'(VMUL)) >> VK);
    out_kind <= kind_nxt;
    out_hit <= hit_nxt;
    out_ip_out <= oip_nxt;
    out_port_out <= oport_nxt;
    out_mac_out <= omac_nxt;
    out_last <= last_nxt;
  end

  always_comb begin
    logic [8:0] age1;
    logic fb;
    st_nxt = st_r;
    lfsr_nxt = lfsr_r;
    ev_nxt = ev_r;
    rv_nxt = rv_r;
    ccnt_nxt = ccnt_r;
    rcnt_nxt = rcnt_r;
    pv_nxt = 1'b0;
    paddr_c_nxt = ccnt_r[CW-1:0];
    paddr_r_nxt = rcnt_r[RW-1:0];
    found_nxt = found_r;
    fidx_nxt = fidx_r;
    fmac_nxt = fmac_r;
    freef_nxt = freef_r;
    ridx_nxt = ridx_r;
    hkind_nxt = hkind_r;
    hport_nxt = hport_r;
    c_we = 1'b0;
    c_waddr = paddr_c_r;
    c_wdata = c_rdata;
    c_raddr = ccnt_r[CW-1:0];
    r_we = 1'b0;
    r_waddr = paddr_r_r;
    r_wdata = r_rdata;
    r_raddr = rcnt_r[RW-1:0];
    ov_nxt = 1'b0;
    kind_nxt = arpc_pkg::K_LOOKUP;
    hit_nxt = 1'b0;
    oip_nxt = '0;
    oport_nxt = '0;
    omac_nxt = '0;
    last_nxt = 1'b0;
    age1 = {1'b0, c_rdata[7:0]} + 9'd1;
    fb = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];
    unique case (st_r)
      arpc_pkg::ST_IDLE: begin
        ccnt_nxt = '0;
        rcnt_nxt = '0;
        found_nxt = 1'b0;
        freef_nxt = 1'b0;
        if (start) begin
          st_nxt = (in_action == arpc_pkg::ACT_APPEND) ? arpc_pkg::ST_RSCAN
                                                      : arpc_pkg::ST_CSCAN;
        end
      end
      arpc_pkg::ST_CSCAN: begin
        if (ccnt_r < CCW'(CACHE_DEPTH)) begin
          ccnt_nxt = ccnt_r + 1'b1;
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          if (act_r == arpc_pkg::ACT_TICK) begin
            if (ev_r[paddr_c_r]) begin
              if (age1 > {1'b0, tmo_r}) ev_nxt[paddr_c_r] = 1'b0;
              else begin
                c_we = 1'b1;
                c_wdata = {c_rdata[87:8], age1[7:0]};
              end
            end
          end else if (ev_r[paddr_c_r] && cmp.ip_eq && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt = paddr_c_r;
            fmac_nxt = c_rdata[55:8];
          end
        end
        if (!pv_nxt && !pv_r && ccnt_r == CCW'(CACHE_DEPTH)) begin
          unique case (act_r)
            arpc_pkg::ACT_LOOKUP: begin
              ov_nxt = 1'b1;
              kind_nxt = arpc_pkg::K_LOOKUP;
              hit_nxt = found_r;
              oip_nxt = ip_r;
              omac_nxt = found_r ? fmac_r : '0;
              last_nxt = 1'b1;
              st_nxt = arpc_pkg::ST_IDLE;
            end
            arpc_pkg::ACT_INSERT: st_nxt = arpc_pkg::ST_CWRITE;
            default: st_nxt = arpc_pkg::ST_RSCAN;
          endcase
        end
      end
      arpc_pkg::ST_CWRITE: begin
        c_we = 1'b1;
        c_wdata = {ip_r, mac_r, 8'd0};
        if (found_r) c_waddr = fidx_r;
        else if (!(&ev_r)) begin
          c_waddr = fidx_r;
          for (int i = CACHE_DEPTH - 1; i >= 0; i--)
            if (!ev_r[i]) c_waddr = CW'(i);
        end else begin
          c_waddr = vrem[CW-1:0];
          lfsr_nxt = {fb, lfsr_r[15:1]};
        end
        ev_nxt[c_waddr] = 1'b1;
        // insert done waits for the request scan to learn whether it is last
        hkind_nxt = arpc_pkg::K_INSERT;
        hport_nxt = '0;
        st_nxt = arpc_pkg::ST_RSCAN;
      end
      arpc_pkg::ST_RSCAN: begin
        if (rcnt_r < RCW'(REQUEST_DEPTH)) begin
          rcnt_nxt = rcnt_r + 1'b1;
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          unique case (act_r)
            arpc_pkg::ACT_INSERT: begin
              // a match lets the held result go, and the release is held instead
              if (rv_r[paddr_r_r] && cmp.ip_eq) begin
                rv_nxt[paddr_r_r] = 1'b0;
                ov_nxt = 1'b1;
                kind_nxt = hkind_r;
                oip_nxt = ip_r;
                oport_nxt = hport_r;
                omac_nxt = mac_r;
                hkind_nxt = arpc_pkg::K_RELEASE;
                hport_nxt = r_rdata[7:4];
              end
            end
            arpc_pkg::ACT_APPEND: begin
              if (rv_r[paddr_r_r] && cmp.ip_eq && cmp.port_eq) found_nxt = 1'b1;
              if (!rv_r[paddr_r_r] && !freef_r) begin
                freef_nxt = 1'b1;
                ridx_nxt = paddr_r_r;
              end
            end
            default: begin
              if (rv_r[paddr_r_r]) begin
                ov_nxt = 1'b1;
                oip_nxt = r_rdata[39:8];
                oport_nxt = r_rdata[7:4];
                if (r_rdata[3:0] >= tries_max_r) begin
                  kind_nxt = arpc_pkg::K_UNREACH;
                  rv_nxt[paddr_r_r] = 1'b0;
                end else begin
                  kind_nxt = arpc_pkg::K_SEND;
                  r_we = 1'b1;
                  r_wdata = {r_rdata[39:4], r_rdata[3:0] + 4'd1};
                end
              end
            end
          endcase
        end
        if (!pv_nxt && !pv_r && rcnt_r == RCW'(REQUEST_DEPTH)) begin
          if (act_r == arpc_pkg::ACT_APPEND) begin
            ov_nxt = 1'b1;
            oip_nxt = ip_r;
            oport_nxt = port_r;
            last_nxt = 1'b1;
            if (found_r) kind_nxt = arpc_pkg::K_QUEUED;
            else if (freef_r) begin
              kind_nxt = arpc_pkg::K_SEND;
              r_we = 1'b1;
              r_waddr = ridx_r;
              r_wdata = {ip_r, port_r, 4'd1};
              rv_nxt[ridx_r] = 1'b1;
            end else kind_nxt = arpc_pkg::K_FULL;
            st_nxt = arpc_pkg::ST_IDLE;
          end else if (act_r == arpc_pkg::ACT_TICK) begin
            st_nxt = arpc_pkg::ST_DONE;
          end else begin
            // insert: the held result is the final one
            ov_nxt = 1'b1;
            kind_nxt = hkind_r;
            oip_nxt = ip_r;
            oport_nxt = hport_r;
            omac_nxt = mac_r;
            last_nxt = 1'b1;
            st_nxt = arpc_pkg::ST_IDLE;
          end
        end
      end
      arpc_pkg::ST_DONE: begin
        ov_nxt = 1'b1;
        kind_nxt = arpc_pkg::K_TICK;
        last_nxt = 1'b1;
        st_nxt = arpc_pkg::ST_IDLE;
      end
      default: st_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `ASSERT_NEVER(a_no_out_idle_pre, clk, rst_n, out_valid && $past(st_r == arpc_pkg::ST_IDLE))
  `ASSERT_IMPL(a_last_to_idle, clk, rst_n, (out_valid && out_last) |-> !busy)
endmodule
